@@ hw/rtl/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg
// Types, constants and codes shared by the trial division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int DATA_W              = 64;
   localparam int LIMIT_W             = 33;
   localparam int FUNC_W              = 2;
   localparam int DIV_CNT_W           = $clog2(DATA_W);
   localparam int TABLE_DEPTH_DEFAULT = 16384;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {1'b1, {(LIMIT_W-1){1'b0}}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_TEST  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_table;
      logic load_entry;
      logic latch_cand;
      logic adv_pos;
      logic read_entry;
      logic latch_div;
      logic start_div;
      logic set_result;
      logic result_prime;
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic table_empty;
      logic entry_zero;
      logic above_limit;
      logic rem_zero;
      logic last_entry;
      logic div_busy;
      logic rsp_free;
   } status_type;

endpackage

@@ hw/rtl/tdpt_req_if.sv @@
// ----------------------------------------------------------------------------
// tdpt_req_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpt_req_if;
   import tdpt_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);

endinterface

@@ hw/rtl/tdpt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tdpt_rsp_if
// Response channel: tested number and prime flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpt_rsp_if;
   import tdpt_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] number;
   logic              prime_flag;

   modport source (output valid, output number, output prime_flag, input ready);
   modport sink   (input valid, input number, input prime_flag, output ready);

endinterface

@@ hw/rtl/trial_division_prime_tester.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_tester
// Trial division primality test against a loadable table of primes.
// ----------------------------------------------------------------------------
// A clear empties the table and a load appends one entry; a load into a full
// table is dropped. A test transaction walks the table from its first entry:
// each entry is read and latched as the divisor, a nonzero entry then runs
// through the bit-serial remainder unit and is evaluated, and a zero entry
// is skipped. The walk stops at the first dividing entry, after the first
// entry above the trial limit, or at the last loaded entry. Requests are held
// off until the test result has been placed in the response register; that
// register holds one result while the next clear or load is accepted.
module trial_division_prime_tester #(
   parameter int TABLE_DEPTH = tdpt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   tdpt_req_if.sink                     req_ch,
   tdpt_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [tdpt_pkg::LIMIT_W-1:0] csr_wdata
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_func  (req_ch.func),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_ch.value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_number     (rsp_ch.number),
      .rsp_prime_flag (rsp_ch.prime_flag)
   );

   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> status.div_busy)
      else $error("remainder unit did not start");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.set_result |-> status.rsp_free)
      else $error("result written over an untaken transaction");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_entry |-> !status.table_full)
      else $error("load into a full table");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.adv_pos |-> !status.last_entry)
      else $error("walk advanced past the last entry");

endmodule

@@ hw/rtl/tdpt_divider.sv @@
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdpt_pkg::DATA_W-1:0] dividend,
   input  logic [tdpt_pkg::DATA_W-1:0] divisor,
   output logic                        busy,
   output logic [tdpt_pkg::DATA_W-1:0] remainder
);
   import tdpt_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]    quot_ff, quot_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    div_ff, div_in;
   logic [DATA_W:0]      trial;
   logic [DATA_W:0]      diff;

   always_comb begin
      trial    = {rem_ff, quot_ff[DATA_W-1]};
      diff     = trial - {1'b0, div_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DATA_W - 1);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DATA_W-2:0], 1'b0};
         rem_in   = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/tdpt_datapath.sv @@
// ----------------------------------------------------------------------------
// tdpt_datapath
// Prime table, walk position, candidate, trial limit and result register.
// ----------------------------------------------------------------------------
module tdpt_datapath #(
   parameter int TABLE_DEPTH = tdpt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tdpt_pkg::cmd_type            cmd,
   output tdpt_pkg::status_type         status,
   input  logic [tdpt_pkg::DATA_W-1:0]  req_value,
   input  logic                         csr_we,
   input  logic [tdpt_pkg::LIMIT_W-1:0] csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tdpt_pkg::DATA_W-1:0]  rsp_number,
   output logic                         rsp_prime_flag
);
   import tdpt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   logic [DATA_W-1:0]  table_mem [TABLE_DEPTH];
   logic [DATA_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0]  cand_ff, cand_in;
   logic [DATA_W-1:0]  divisor_ff, divisor_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  number_ff, number_in;
   logic               prime_ff, prime_in;
   logic               div_busy;
   logic [DATA_W-1:0]  remainder;
   logic [CNT_W-1:0]   pos_next;

   tdpt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (cand_ff),
      .divisor   (divisor_ff),
      .busy      (div_busy),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         table_mem[count_ff[ADDR_W-1:0]] <= req_value;
      end
      if (cmd.read_entry) begin
         rd_data_ff <= table_mem[pos_ff];
      end
   end

   always_comb begin
      pos_next     = {1'b0, pos_ff} + CNT_W'(1);
      count_in     = count_ff;
      pos_in       = pos_ff;
      cand_in      = cand_ff;
      divisor_in   = divisor_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      number_in    = number_ff;
      prime_in     = prime_ff;
      if (cmd.clear_table) begin
         count_in = '0;
         pos_in   = '0;
      end
      if (cmd.load_entry) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.latch_cand) begin
         cand_in = req_value;
         pos_in  = '0;
      end
      if (cmd.adv_pos) begin
         pos_in = pos_next[ADDR_W-1:0];
      end
      if (cmd.latch_div) begin
         divisor_in = rd_data_ff;
      end
      if (csr_we) begin
         limit_in = csr_wdata;
      end
      if (cmd.set_result) begin
         rsp_valid_in = 1'b1;
         number_in    = cand_ff;
         prime_in     = cmd.result_prime;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff    <= cand_in;
      divisor_ff <= divisor_in;
      number_ff  <= number_in;
      prime_ff   <= prime_in;
   end

   always_comb begin
      status.table_full  = (count_ff == CNT_W'(TABLE_DEPTH));
      status.table_empty = (count_ff == '0);
      status.entry_zero  = (divisor_ff == '0);
      status.above_limit = (divisor_ff > {{(DATA_W-LIMIT_W){1'b0}}, limit_ff});
      status.rem_zero    = (remainder == '0);
      status.last_entry  = (pos_next >= count_ff);
      status.div_busy    = div_busy;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_number     = number_ff;
   assign rsp_prime_flag = prime_ff;

endmodule

@@ hw/rtl/tdpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for table loads and the trial division walk.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tdpt_pkg::FUNC_W-1:0] req_func,
   input  tdpt_pkg::status_type        status,
   output tdpt_pkg::cmd_type           cmd
);
   import tdpt_pkg::*;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;
   logic      accept;
   func_type  func;

   assign func      = func_type'(req_func);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && func == FUNC_TEST) begin
               verdict_in = 1'b1;
               state_in   = status.table_empty ? ST_FINISH : ST_READ;
            end
         end
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (!status.entry_zero) begin
               state_in = ST_DIV;
            end else if (status.last_entry) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.above_limit || status.last_entry) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.result_prime = verdict_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_CLEAR: cmd.clear_table = 1'b1;
                  FUNC_LOAD:  cmd.load_entry  = !status.table_full;
                  FUNC_TEST:  cmd.latch_cand  = 1'b1;
                  default:    cmd.clear_table = 1'b0;
               endcase
            end
         end
         ST_READ:  cmd.read_entry = 1'b1;
         ST_LOAD:  cmd.latch_div  = 1'b1;
         ST_CHECK: begin
            cmd.start_div = !status.entry_zero;
            cmd.adv_pos   = status.entry_zero && !status.last_entry;
         end
         ST_EVAL: begin
            cmd.adv_pos = !status.rem_zero && !status.above_limit && !status.last_entry;
         end
         ST_FINISH: cmd.set_result = status.rsp_free;
         default:   cmd.set_result = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         verdict_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule
